>>> rtl/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
// Holds the request/result word layouts, the table entry layout and the function/status codes.
// No dependencies.
package ffba_pkg;

  localparam logic [1:0] FN_MALLOC  = 2'd0;
  localparam logic [1:0] FN_CALLOC  = 2'd1;
  localparam logic [1:0] FN_FREE    = 2'd2;
  localparam logic [1:0] FN_REALLOC = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic [1:0] CFG_HEAP_BASE    = 2'd0;
  localparam logic [1:0] CFG_HEAP_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;
  localparam logic [1:0] CFG_MAX_REQUEST  = 2'd3;

  localparam logic [31:0] HEAP_LIMIT_RESET   = 32'd1048576;
  localparam logic [7:0]  HEADER_BYTES_RESET = 8'd32;
  localparam logic [31:0] MAX_REQUEST_RESET  = 32'd100000000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] size;
    logic [15:0] count;
    logic [31:0] address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload_address;
    logic        copy_needed;
    logic [31:0] copy_bytes;
    logic [6:0]  free_block_count;
    logic [31:0] free_byte_total;
    logic [6:0]  block_total;
    logic [31:0] byte_total;
    logic [13:0] header_byte_total;
  } out_word_t;

  typedef struct packed {
    logic        free;
    logic [31:0] start;
    logic [31:0] size;
  } entry_t;

endpackage

>>> rtl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/first_fit_block_allocator.sv
// First-fit heap block allocator (no splitting): malloc, calloc, free and realloc over a block
// table held in one RAM (ffba_ram), walked by a small sequencer one entry per cycle.
// Depends on ffba_pkg and ffba_ram.
//
// One request is in flight at a time; in_stall is high from acceptance until the result is
// loaded into the output register. The first-fit and address searches read the table through the
// single RAM read port, one entry per cycle, over the N blocks created so far (at most TABLE_DEPTH).
// A realloc that must move its block searches twice. A bad size or a free of address zero skips
// the table search. The next request is taken while the last result still waits in the output
// register. The table needs no clearing after reset.
module first_fit_block_allocator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffba_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ffba_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  import ffba_pkg::*;

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int EW   = $bits(entry_t);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b00000001,
    S_CHECK   = 8'b00000010,
    S_FIND    = 8'b00000100,
    S_FIT     = 8'b00001000,
    S_APPEND  = 8'b00010000,
    S_RELEASE = 8'b00100000,
    S_DONE    = 8'b01000000,
    S_SPARE   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] heap_base_r, heap_limit_r, max_request_r;
  logic [7:0]  header_bytes_r;

  logic [1:0]  func_r, func_nxt;
  logic [47:0] total_r, total_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] res_r, res_nxt;
  logic        copy_r, copy_nxt;
  logic [31:0] copy_bytes_r, copy_bytes_nxt;
  logic        found_r, found_nxt;
  logic [IDXW-1:0] scan_r, scan_nxt;
  logic [IDXW-1:0] old_idx_r, old_idx_nxt;
  logic [31:0] old_size_r, old_size_nxt;
  logic [31:0] old_start_r, old_start_nxt;
  logic        old_free_r, old_free_nxt;

  logic [CNTW-1:0] used_r, used_nxt;
  logic [CNTW-1:0] free_cnt_r, free_cnt_nxt;
  logic [31:0] break_r, break_nxt;
  logic [31:0] free_sum_r, free_sum_nxt;
  logic [31:0] payload_bytes_r, payload_bytes_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic            ram_we;
  logic [IDXW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, rd_entry;
  logic [EW-1:0]   ram_rdata;

  logic [31:0]     sz;
  logic            size_bad;
  logic [CNTW-1:0] scan_next;
  logic            scan_last;
  logic [33:0]     break_need;
  logic            no_room;

  assign rd_entry   = entry_t'(ram_rdata);
  assign sz         = total_r[31:0];
  assign size_bad   = (total_r == 48'd0) || (total_r > {16'd0, max_request_r});
  assign scan_next  = CNTW'(scan_r) + CNTW'(1);
  assign scan_last  = (scan_next == used_r);
  assign break_need = {2'b00, break_r} + {26'd0, header_bytes_r} + {2'b00, sz};
  assign no_room    = (used_r >= CNTW'(TABLE_DEPTH)) || (break_need > {2'b00, heap_limit_r});

  ffba_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  always_comb begin
    state_nxt         = state_r;
    func_nxt          = func_r;
    total_nxt         = total_r;
    addr_nxt          = addr_r;
    status_nxt        = status_r;
    res_nxt           = res_r;
    copy_nxt          = copy_r;
    copy_bytes_nxt    = copy_bytes_r;
    found_nxt         = found_r;
    scan_nxt          = scan_r;
    old_idx_nxt       = old_idx_r;
    old_size_nxt      = old_size_r;
    old_start_nxt     = old_start_r;
    old_free_nxt      = old_free_r;
    used_nxt          = used_r;
    free_cnt_nxt      = free_cnt_r;
    break_nxt         = break_r;
    free_sum_nxt      = free_sum_r;
    payload_bytes_nxt = payload_bytes_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_word_nxt      = out_word_r;
    ram_we            = 1'b0;
    ram_waddr         = scan_r;
    ram_wdata         = rd_entry;
    ram_raddr         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt       = in_word.func;
          total_nxt      = (in_word.func == FN_CALLOC) ?
                           (48'(in_word.count) * 48'(in_word.size)) : 48'(in_word.size);
          addr_nxt       = in_word.address;
          status_nxt     = ST_OK;
          res_nxt        = '0;
          copy_nxt       = 1'b0;
          copy_bytes_nxt = '0;
          found_nxt      = 1'b0;
          state_nxt      = S_CHECK;
        end
      end

      S_CHECK: begin
        scan_nxt = '0;
        case (func_r)
          FN_FREE: begin
            if (addr_r == 32'd0 || used_r == '0) begin
              status_nxt = ST_IGNORED;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FIND;
            end
          end
          FN_REALLOC: begin
            if (size_bad) begin
              status_nxt = ST_BAD_SIZE;
              state_nxt  = S_DONE;
            end else if (addr_r == 32'd0 || used_r == '0) begin
              state_nxt = (used_r == '0) ? S_APPEND : S_FIT;
            end else begin
              state_nxt = S_FIND;
            end
          end
          default: begin
            if (size_bad) begin
              status_nxt = ST_BAD_SIZE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = (used_r == '0) ? S_APPEND : S_FIT;
            end
          end
        endcase
      end

      S_FIND: begin
        if (rd_entry.start == addr_r) begin
          old_idx_nxt   = scan_r;
          old_size_nxt  = rd_entry.size;
          old_start_nxt = rd_entry.start;
          old_free_nxt  = rd_entry.free;
          if (func_r == FN_FREE) begin
            if (rd_entry.free) begin
              status_nxt = ST_IGNORED;
            end else begin
              ram_we         = 1'b1;
              ram_wdata.free = 1'b1;
              free_cnt_nxt   = free_cnt_r + CNTW'(1);
              free_sum_nxt   = free_sum_r + rd_entry.size;
            end
            state_nxt = S_DONE;
          end else if (rd_entry.size >= sz) begin
            res_nxt   = rd_entry.start;
            state_nxt = S_DONE;
          end else begin
            found_nxt = 1'b1;
            scan_nxt  = '0;
            state_nxt = S_FIT;
          end
        end else if (scan_last) begin
          if (func_r == FN_FREE) begin
            status_nxt = ST_IGNORED;
            state_nxt  = S_DONE;
          end else begin
            scan_nxt  = '0;
            state_nxt = S_FIT;
          end
        end else begin
          scan_nxt  = scan_next[IDXW-1:0];
          ram_raddr = scan_next[IDXW-1:0];
        end
      end

      S_FIT: begin
        if (rd_entry.free && rd_entry.size >= sz) begin
          ram_we         = 1'b1;
          ram_wdata.free = 1'b0;
          free_cnt_nxt   = free_cnt_r - CNTW'(1);
          free_sum_nxt   = free_sum_r - rd_entry.size;
          res_nxt        = rd_entry.start;
          state_nxt      = found_r ? S_RELEASE : S_DONE;
        end else if (scan_last) begin
          state_nxt = S_APPEND;
        end else begin
          scan_nxt  = scan_next[IDXW-1:0];
          ram_raddr = scan_next[IDXW-1:0];
        end
      end

      S_APPEND: begin
        if (no_room) begin
          status_nxt = ST_NO_SPACE;
          state_nxt  = S_DONE;
        end else begin
          ram_we            = 1'b1;
          ram_waddr         = used_r[IDXW-1:0];
          ram_wdata.free    = 1'b0;
          ram_wdata.size    = sz;
          ram_wdata.start   = heap_base_r + break_r + 32'(header_bytes_r);
          res_nxt           = heap_base_r + break_r + 32'(header_bytes_r);
          used_nxt          = used_r + CNTW'(1);
          break_nxt         = break_need[31:0];
          payload_bytes_nxt = payload_bytes_r + sz;
          state_nxt         = found_r ? S_RELEASE : S_DONE;
        end
      end

      S_RELEASE: begin
        copy_nxt       = 1'b1;
        copy_bytes_nxt = old_size_r;
        if (!old_free_r) begin
          ram_we          = 1'b1;
          ram_waddr       = old_idx_r;
          ram_wdata.free  = 1'b1;
          ram_wdata.size  = old_size_r;
          ram_wdata.start = old_start_r;
          free_cnt_nxt    = free_cnt_r + CNTW'(1);
          free_sum_nxt    = free_sum_r + old_size_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                  = 1'b1;
          out_word_nxt.status            = status_r;
          out_word_nxt.payload_address   = res_r;
          out_word_nxt.copy_needed       = copy_r;
          out_word_nxt.copy_bytes        = copy_bytes_r;
          out_word_nxt.free_block_count  = 7'(free_cnt_r);
          out_word_nxt.free_byte_total   = free_sum_r;
          out_word_nxt.block_total       = 7'(used_r);
          out_word_nxt.byte_total        = payload_bytes_r;
          out_word_nxt.header_byte_total = 14'(used_r) * 14'(header_bytes_r);
          state_nxt                      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      used_r          <= '0;
      free_cnt_r      <= '0;
      break_r         <= '0;
      free_sum_r      <= '0;
      payload_bytes_r <= '0;
      out_valid_r     <= 1'b0;
      found_r         <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      used_r          <= used_nxt;
      free_cnt_r      <= free_cnt_nxt;
      break_r         <= break_nxt;
      free_sum_r      <= free_sum_nxt;
      payload_bytes_r <= payload_bytes_nxt;
      out_valid_r     <= out_valid_nxt;
      found_r         <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    total_r      <= total_nxt;
    addr_r       <= addr_nxt;
    status_r     <= status_nxt;
    res_r        <= res_nxt;
    copy_r       <= copy_nxt;
    copy_bytes_r <= copy_bytes_nxt;
    scan_r       <= scan_nxt;
    old_idx_r    <= old_idx_nxt;
    old_size_r   <= old_size_nxt;
    old_start_r  <= old_start_nxt;
    old_free_r   <= old_free_nxt;
    out_word_r   <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r    <= '0;
      heap_limit_r   <= HEAP_LIMIT_RESET;
      header_bytes_r <= HEADER_BYTES_RESET;
      max_request_r  <= MAX_REQUEST_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEAP_BASE:    heap_base_r    <= cfg_data;
        CFG_HEAP_LIMIT:   heap_limit_r   <= cfg_data;
        CFG_HEADER_BYTES: header_bytes_r <= cfg_data[7:0];
        CFG_MAX_REQUEST:  max_request_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> bench/testbench.sv
// Self-checking bench for first_fit_block_allocator: directed and random heap requests under
// several register settings, with results predicted by an in-bench heap ledger.
// Depends on ffba_pkg and the allocator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  localparam int DEPTH = 64;

  class heap_ledger;
    logic [31:0] base, limit, max_size;
    logic [7:0]  hdr;
    logic [31:0] blk_size [DEPTH];
    logic [31:0] blk_start [DEPTH];
    bit          blk_free [DEPTH];
    int          n_blocks, n_free;
    logic [31:0] brk, free_sum, used_bytes;
    out_word_t   replies_due [$];
    int          n_wrong;

    function new();
      base = '0;
      limit = HEAP_LIMIT_RESET;
      hdr = HEADER_BYTES_RESET;
      max_size = MAX_REQUEST_RESET;
      n_blocks = 0;
      n_free = 0;
      brk = '0;
      free_sum = '0;
      used_bytes = '0;
      n_wrong = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_HEAP_BASE:    base = data;
        CFG_HEAP_LIMIT:   limit = data;
        CFG_HEADER_BYTES: hdr = data[7:0];
        CFG_MAX_REQUEST:  max_size = data;
        default: ;
      endcase
    endfunction

    function bit size_bad(logic [63:0] sz);
      return sz == 64'd0 || sz > {32'd0, max_size};
    endfunction

    function logic [1:0] claim_block(logic [31:0] sz, output logic [31:0] addr);
      logic [63:0] need;
      int i;
      addr = '0;
      for (i = 0; i < n_blocks; i++) begin
        if (blk_free[i] && blk_size[i] >= sz) begin
          blk_free[i] = 1'b0;
          n_free--;
          free_sum -= blk_size[i];
          addr = blk_start[i];
          return ST_OK;
        end
      end
      if (n_blocks >= DEPTH) return ST_NO_SPACE;
      need = {56'd0, hdr} + {32'd0, sz};
      if ({32'd0, brk} + need > {32'd0, limit}) return ST_NO_SPACE;
      blk_size[n_blocks] = sz;
      blk_start[n_blocks] = base + brk + {24'd0, hdr};
      blk_free[n_blocks] = 1'b0;
      addr = blk_start[n_blocks];
      n_blocks++;
      brk = brk + need[31:0];
      used_bytes += sz;
      return ST_OK;
    endfunction

    function int find_block(logic [31:0] addr);
      int i;
      if (addr == '0) return DEPTH;
      for (i = 0; i < n_blocks; i++)
        if (blk_start[i] == addr) return i;
      return DEPTH;
    endfunction

    function void take_request(in_word_t w);
      out_word_t   e;
      logic [63:0] total;
      logic [31:0] addr;
      int          idx;
      e = '0;
      addr = '0;
      case (w.func)
        FN_MALLOC: begin
          if (size_bad({32'd0, w.size})) e.status = ST_BAD_SIZE;
          else e.status = claim_block(w.size, addr);
        end
        FN_CALLOC: begin
          total = {48'd0, w.count} * {32'd0, w.size};
          if (size_bad(total)) e.status = ST_BAD_SIZE;
          else e.status = claim_block(total[31:0], addr);
        end
        FN_FREE: begin
          idx = find_block(w.address);
          if (idx >= DEPTH || blk_free[idx]) begin
            e.status = ST_IGNORED;
          end else begin
            blk_free[idx] = 1'b1;
            n_free++;
            free_sum += blk_size[idx];
          end
        end
        FN_REALLOC: begin
          if (size_bad({32'd0, w.size})) begin
            e.status = ST_BAD_SIZE;
          end else begin
            idx = find_block(w.address);
            if (idx >= DEPTH) begin
              e.status = claim_block(w.size, addr);
            end else if (blk_size[idx] >= w.size) begin
              addr = blk_start[idx];
            end else begin
              e.status = claim_block(w.size, addr);
              if (e.status == ST_OK) begin
                e.copy_needed = 1'b1;
                e.copy_bytes = blk_size[idx];
                if (!blk_free[idx]) begin
                  blk_free[idx] = 1'b1;
                  n_free++;
                  free_sum += blk_size[idx];
                end
              end
            end
          end
        end
        default: ;
      endcase
      e.payload_address = addr;
      e.free_block_count = 7'(n_free);
      e.free_byte_total = free_sum;
      e.block_total = 7'(n_blocks);
      e.byte_total = used_bytes;
      e.header_byte_total = 14'(n_blocks * hdr);
      replies_due.push_back(e);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        n_wrong++;
        if (n_wrong <= 10)
          $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void match_reply(out_word_t got);
      out_word_t e;
      if (replies_due.size() == 0) begin
        n_wrong++;
        if (n_wrong <= 10) $display("%0t: result word with none outstanding", $time);
        return;
      end
      e = replies_due.pop_front();
      check_field("status", e.status, got.status);
      check_field("payload_address", e.payload_address, got.payload_address);
      check_field("copy_needed", e.copy_needed, got.copy_needed);
      check_field("copy_bytes", e.copy_bytes, got.copy_bytes);
      check_field("free_block_count", e.free_block_count, got.free_block_count);
      check_field("free_byte_total", e.free_byte_total, got.free_byte_total);
      check_field("block_total", e.block_total, got.block_total);
      check_field("byte_total", e.byte_total, got.byte_total);
      check_field("header_byte_total", e.header_byte_total, got.header_byte_total);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        hold_off;

  heap_ledger book;
  int         n_sent = 0;
  bit         sender_busy = 1'b0;

  first_fit_block_allocator #(.TABLE_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic in_word_t req(logic [1:0] func, logic [31:0] size, logic [15:0] count,
                                   logic [31:0] address);
    in_word_t w;
    w.func = func;
    w.size = size;
    w.count = count;
    w.address = address;
    return w;
  endfunction

  function automatic logic [31:0] pick_size();
    int k;
    k = $urandom_range(0, 19);
    case (k)
      0: return 32'd0;
      1: return $urandom;
      2: return book.max_size;
      3: return book.max_size + 32'd1;
      4: begin
        if (book.n_blocks > 0) return book.blk_size[$urandom_range(0, book.n_blocks - 1)];
        else return 32'd1;
      end
      5: return $urandom_range(300, 5000);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  function automatic logic [31:0] pick_address();
    int          k;
    logic [31:0] known;
    k = $urandom_range(0, 9);
    if (book.n_blocks == 0) return $urandom;
    known = book.blk_start[$urandom_range(0, book.n_blocks - 1)];
    case (k)
      0: return 32'd0;
      1: return $urandom;
      2: return known + 32'd1;
      default: return known;
    endcase
  endfunction

  function automatic in_word_t random_request();
    in_word_t w;
    int       r;
    int       k;
    r = $urandom_range(0, 99);
    w.func = (r < 30) ? FN_MALLOC : (r < 45) ? FN_CALLOC : (r < 75) ? FN_FREE : FN_REALLOC;
    w.size = pick_size();
    w.count = 16'($urandom);
    w.address = $urandom;
    if (w.func == FN_CALLOC) begin
      k = $urandom_range(0, 9);
      w.count = (k == 0) ? 16'd0 : (k == 1) ? 16'($urandom) : 16'($urandom_range(1, 16));
      if ($urandom_range(0, 3) != 0) w.size = $urandom_range(1, 32);
    end
    if (w.func == FN_FREE || w.func == FN_REALLOC) w.address = pick_address();
    return w;
  endfunction

  task automatic send(in_word_t w);
    int gap;
    gap = sender_busy ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    book.take_request(w);
    n_sent++;
    if (n_sent % 100 == 0) sender_busy = ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (book.replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(idx, data);
  endtask

  task automatic program_heap(logic [31:0] base, logic [31:0] limit, logic [7:0] hdr,
                              logic [31:0] max_size);
    put_reg(CFG_HEAP_BASE, base);
    put_reg(CFG_HEAP_LIMIT, limit);
    put_reg(CFG_HEADER_BYTES, {24'd0, hdr});
    put_reg(CFG_MAX_REQUEST, max_size);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) send(random_request());
    drain();
  endtask

  initial begin : result_sink
    int stall_left;
    int n_got;
    bit quiet;
    out_stall = 1'b0;
    stall_left = 0;
    n_got = 0;
    quiet = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        book.match_reply(out_word);
        n_got++;
        if (n_got % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
        stall_left = quiet ? 0 : $urandom_range(0, 8);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0) || hold_off;
    end
  end

  // hold the result side off while requests keep coming, so the input backs up
  initial begin : long_hold
    hold_off = 1'b0;
    wait (n_sent >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (500) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #20ms;
    $display("[first_fit_block_allocator] ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HEAP_BASE;
    cfg_data = '0;
    book = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(req(FN_MALLOC, 32'd0, 16'd0, 32'd0));
    send(req(FN_MALLOC, MAX_REQUEST_RESET + 32'd1, 16'd0, 32'd0));
    send(req(FN_MALLOC, 32'hFFFF_FFFF, 16'd0, 32'd0));
    send(req(FN_MALLOC, 32'd100, 16'd0, 32'd0));
    send(req(FN_MALLOC, MAX_REQUEST_RESET, 16'd0, 32'd0));
    send(req(FN_CALLOC, 32'd8, 16'd0, 32'd0));
    send(req(FN_CALLOC, 32'hFFFF_FFFF, 16'hFFFF, 32'd0));
    send(req(FN_CALLOC, 32'd4, 16'd25, 32'd0));
    send(req(FN_FREE, 32'd0, 16'd0, 32'd0));
    send(req(FN_FREE, 32'd0, 16'd0, book.blk_start[0] + 32'd1));
    send(req(FN_FREE, 32'd0, 16'd0, book.blk_start[0]));
    send(req(FN_FREE, 32'd0, 16'd0, book.blk_start[0]));
    send(req(FN_MALLOC, 32'd60, 16'd0, 32'd0));
    send(req(FN_REALLOC, 32'd40, 16'd0, 32'd0));
    send(req(FN_REALLOC, 32'd40, 16'd0, 32'hDEAD_BEEF));
    send(req(FN_REALLOC, 32'd50, 16'd0, book.blk_start[1]));
    send(req(FN_REALLOC, 32'd0, 16'd0, book.blk_start[1]));
    send(req(FN_REALLOC, 32'd200, 16'd0, book.blk_start[1]));
    send(req(FN_REALLOC, 32'd10, 16'd0, book.blk_start[1]));
    send(req(FN_REALLOC, 32'd500, 16'd0, book.blk_start[1]));
    send(req(FN_REALLOC, 32'd2_000_000, 16'd0, book.blk_start[2]));
    send(req(FN_MALLOC, 32'd1, 16'hFFFF, 32'hFFFF_FFFF));
    send(req(FN_FREE, 32'hFFFF_FFFF, 16'hFFFF, book.blk_start[3]));
    send(req(FN_CALLOC, 32'd1525, 16'hFFFF, 32'd0));
    drain();

    program_heap(32'hFFFF_FF00, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
    run_random(150);
    program_heap(32'd0, 32'd0, 8'd0, 32'd1);
    run_random(120);
    program_heap(32'h10, 32'd8192, 8'd16, 32'd600);
    run_random(350);
    program_heap($urandom, $urandom_range(0, 1 << 20), 8'($urandom_range(0, 255)),
                 $urandom_range(1, 4096));
    run_random(300);
    program_heap(32'h8000_0000, 32'hFFFF_FFFF, 8'd1, 32'hFFFF_FFFF);
    run_random(250);
    program_heap(32'd0, HEAP_LIMIT_RESET, HEADER_BYTES_RESET, MAX_REQUEST_RESET);
    run_random(300);

    repeat (150) @(posedge clk);
    if (book.n_wrong == 0 && book.replies_due.size() == 0)
      $display("[first_fit_block_allocator] OK");
    else
      $display("[first_fit_block_allocator] ERROR");
    $finish;
  end

endmodule
